FILE: hdl/gcmap_pkg.sv
// gcmap_pkg: shared types and constants of the cover map stamp block
// depends on nothing; used by the front, queue, back and top level modules and the testbench
package gcmap_pkg;

   localparam int POS_W      = 7;
   localparam int COORD_W    = 8;
   localparam int AMOUNT_W   = 5;
   localparam int KIND_W     = 2;
   localparam int CMD_W      = 2;
   localparam int CELL_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   localparam logic [CSR_DATA_W-1:0] GRID_SIZE_RESET = 8'd128;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   // cover kinds
   localparam logic [KIND_W-1:0] KIND_NONE       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VEGETATION = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TREE       = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SOLID      = 2'd3;

   // cell flag bit positions
   localparam int FLAG_VEG_BIT   = 5;
   localparam int FLAG_TREE_BIT  = 6;
   localparam int FLAG_SOLID_BIT = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_KIND   = 2'd0,
      CMD_SET_AMOUNT = 2'd1,
      CMD_STAMP_AREA = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   // work handed from front to back
   typedef enum logic [1:0] {
      OP_STAMP      = 2'd0,
      OP_SET_AMOUNT = 2'd1,
      OP_READ       = 2'd2,
      OP_BAD_READ   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [COORD_W-1:0]    x_lo;
      logic [COORD_W-1:0]    x_hi;
      logic [COORD_W-1:0]    y_lo;
      logic [COORD_W-1:0]    y_hi;
      logic [AMOUNT_W-1:0]   amount;
      logic [KIND_W-1:0]     kind;
   } desc_type;

endpackage

FILE: hdl/gcmap_ram.sv
// gcmap_ram: generic single write port, single read port ram with registered read
// depends on nothing
module gcmap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/gcmap_fifo.sv
// gcmap_fifo: two-entry queue of work descriptors between front and back
// depends on gcmap_pkg
module gcmap_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gcmap_pkg::desc_type  push_desc,
   input  logic                 pop,
   output gcmap_pkg::desc_type  head,
   output logic                 full,
   output logic                 empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   gcmap_pkg::desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]      count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + (PTR_W+1)'(1);
         2'b01:   count_in = count_ff - (PTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

FILE: hdl/gcmap_front.sv
// gcmap_front: accepts requests, holds the grid size registers, clips and classifies
// depends on gcmap_pkg
module gcmap_front #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [gcmap_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [gcmap_pkg::CMD_W-1:0]           req_tuser,
   input  logic                                  csr_we,
   input  logic [gcmap_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [gcmap_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                  clearing,
   input  logic                                  fifo_full,
   output logic                                  push,
   output gcmap_pkg::desc_type                   push_desc
);

   localparam int CW = gcmap_pkg::COORD_W;
   localparam int PW = gcmap_pkg::POS_W;

   logic [gcmap_pkg::CSR_DATA_W-1:0] grid_width_ff, grid_width_in;
   logic [gcmap_pkg::CSR_DATA_W-1:0] grid_height_ff, grid_height_in;

   logic [PW-1:0]                    pos_x, pos_y, radius;
   logic [gcmap_pkg::AMOUNT_W-1:0]   amount;
   logic [gcmap_pkg::KIND_W-1:0]     kind;
   logic [CW-1:0]                    cols, rows;
   logic [CW-1:0]                    x_sum, y_sum, x_lo, y_lo, x_hi, y_hi;
   logic                             in_grid, needs_work;

   assign pos_x  = req_tdata[6:0];
   assign pos_y  = req_tdata[13:7];
   assign radius = req_tdata[20:14];
   assign amount = req_tdata[25:21];
   assign kind   = req_tdata[27:26];

   // config writes
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            gcmap_pkg::CSR_GRID_WIDTH:  grid_width_in  = csr_wdata;
            gcmap_pkg::CSR_GRID_HEIGHT: grid_height_in = csr_wdata;
            default:                    grid_width_in  = grid_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= gcmap_pkg::GRID_SIZE_RESET;
         grid_height_ff <= gcmap_pkg::GRID_SIZE_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // grid in use, clipped to the store
   assign cols = (int'(grid_width_ff) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : grid_width_ff;
   assign rows = (int'(grid_height_ff) > MAX_ROWS) ? CW'(MAX_ROWS) : grid_height_ff;

   assign in_grid = ({1'b0, pos_x} < cols) && ({1'b0, pos_y} < rows);

   // square bounds clipped to the grid
   assign x_lo  = (pos_x > radius) ? {1'b0, pos_x - radius} : '0;
   assign y_lo  = (pos_y > radius) ? {1'b0, pos_y - radius} : '0;
   assign x_sum = {1'b0, pos_x} + {1'b0, radius};
   assign y_sum = {1'b0, pos_y} + {1'b0, radius};
   assign x_hi  = (x_sum > cols - CW'(1)) ? cols - CW'(1) : x_sum;
   assign y_hi  = (y_sum > rows - CW'(1)) ? rows - CW'(1) : y_sum;

   always_comb begin
      push_desc.op     = gcmap_pkg::OP_STAMP;
      push_desc.x_lo   = {1'b0, pos_x};
      push_desc.x_hi   = {1'b0, pos_x};
      push_desc.y_lo   = {1'b0, pos_y};
      push_desc.y_hi   = {1'b0, pos_y};
      push_desc.amount = amount;
      push_desc.kind   = kind;
      needs_work       = in_grid;
      unique case (gcmap_pkg::cmd_type'(req_tuser))
         gcmap_pkg::CMD_SET_KIND: begin
            // one-cell stamp with nothing to raise
            push_desc.amount = '0;
         end
         gcmap_pkg::CMD_SET_AMOUNT: begin
            push_desc.op = gcmap_pkg::OP_SET_AMOUNT;
         end
         gcmap_pkg::CMD_STAMP_AREA: begin
            push_desc.x_lo = x_lo;
            push_desc.x_hi = x_hi;
            push_desc.y_lo = y_lo;
            push_desc.y_hi = y_hi;
         end
         gcmap_pkg::CMD_READ: begin
            push_desc.op = in_grid ? gcmap_pkg::OP_READ : gcmap_pkg::OP_BAD_READ;
            needs_work   = 1'b1;
         end
         default: needs_work = in_grid;
      endcase
   end

   assign req_tready = !fifo_full && !clearing;
   assign push       = req_tvalid && req_tready && needs_work;

endmodule

FILE: hdl/gcmap_back.sv
// gcmap_back: walks the cells of each descriptor with read-modify-write on the cell ram,
// runs the clearing pass and owns the result register; depends on gcmap_pkg, gcmap_ram
module gcmap_back #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gcmap_pkg::desc_type                head,
   input  logic                               empty,
   output logic                               pop,
   output logic                               clearing,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gcmap_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [0:0]                         rsp_tuser
);

   localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW     = gcmap_pkg::COORD_W;
   localparam int PROD_W = ADDR_W + CW;
   localparam int AW     = gcmap_pkg::AMOUNT_W;

   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_MODIFY = 2'd2
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] cx,
                                                    input logic [CW-1:0] cy);
      logic [PROD_W-1:0] full_addr;
      full_addr = PROD_W'(cy) * PROD_W'(MAX_COLUMNS) + PROD_W'(cx);
      return full_addr[ADDR_W-1:0];
   endfunction

   state_type                        state_ff, state_in;
   logic [ADDR_W-1:0]                clr_addr_ff, clr_addr_in;
   gcmap_pkg::desc_type              desc_ff, desc_in;
   logic [CW-1:0]                    tx_ff, tx_in, ty_ff, ty_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [gcmap_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                             rsp_bad_ff, rsp_bad_in;

   logic                             ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]                ram_wr_addr, ram_rd_addr;
   logic [gcmap_pkg::CELL_W-1:0]     ram_wr_data, ram_rd_data;

   logic [gcmap_pkg::CELL_W-1:0]     kinded, stamped, amount_set;
   logic [gcmap_pkg::KIND_W-1:0]     top_kind;
   logic                             rsp_free, last_col, last_cell;
   logic [CW-1:0]                    next_tx, next_ty;

   gcmap_ram #(
      .WIDTH (gcmap_pkg::CELL_W),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // cell update
   always_comb begin
      kinded = ram_rd_data;
      case (desc_ff.kind)
         gcmap_pkg::KIND_NONE:       kinded[gcmap_pkg::CELL_W-1:AW] = '0;
         gcmap_pkg::KIND_VEGETATION: kinded[gcmap_pkg::FLAG_VEG_BIT] = 1'b1;
         gcmap_pkg::KIND_TREE:       kinded[gcmap_pkg::FLAG_TREE_BIT] = 1'b1;
         default:                    kinded[gcmap_pkg::FLAG_SOLID_BIT] = 1'b1;
      endcase
      stamped = kinded;
      if (kinded[AW-1:0] < desc_ff.amount) begin
         stamped[AW-1:0] = desc_ff.amount;
      end
      amount_set = {ram_rd_data[gcmap_pkg::CELL_W-1:AW], desc_ff.amount};
      if (ram_rd_data[gcmap_pkg::FLAG_VEG_BIT]) begin
         top_kind = gcmap_pkg::KIND_VEGETATION;
      end else if (ram_rd_data[gcmap_pkg::FLAG_TREE_BIT]) begin
         top_kind = gcmap_pkg::KIND_TREE;
      end else if (ram_rd_data[gcmap_pkg::FLAG_SOLID_BIT]) begin
         top_kind = gcmap_pkg::KIND_SOLID;
      end else begin
         top_kind = gcmap_pkg::KIND_NONE;
      end
   end

   // row-major walk over the square
   assign last_col  = (tx_ff == desc_ff.x_hi);
   assign last_cell = last_col && (ty_ff == desc_ff.y_hi);
   assign next_tx   = last_col ? desc_ff.x_lo : tx_ff + CW'(1);
   assign next_ty   = last_col ? ty_ff + CW'(1) : ty_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      desc_in      = desc_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cell_addr(tx_ff, ty_ff);
      ram_wr_data  = stamped;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cell_addr(next_tx, next_ty);
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               if (head.op == gcmap_pkg::OP_BAD_READ) begin
                  // answered without touching the store
                  if (rsp_free) begin
                     pop          = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_bad_in   = 1'b1;
                  end
               end else begin
                  pop         = 1'b1;
                  desc_in     = head;
                  tx_in       = head.x_lo;
                  ty_in       = head.y_lo;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = cell_addr(head.x_lo, head.y_lo);
                  state_in    = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            if (desc_ff.op == gcmap_pkg::OP_READ) begin
               // read data holds in the ram output until the result slot frees
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {1'b0, top_kind, ram_rd_data[AW-1:0]};
                  rsp_bad_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = (desc_ff.op == gcmap_pkg::OP_SET_AMOUNT) ? amount_set : stamped;
               if (last_cell) begin
                  state_in = ST_IDLE;
               end else begin
                  // next cell read overlaps this cell's write
                  tx_in     = next_tx;
                  ty_in     = next_ty;
                  ram_rd_en = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         desc_ff      <= desc_in;
         tx_ff        <= tx_in;
         ty_ff        <= ty_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_bad_ff   <= rsp_bad_in;
      end
   end

   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule

FILE: hdl/grid_cover_map_area_stamp.sv
// grid_cover_map_area_stamp: top level of the cover map with area stamping
// depends on gcmap_pkg, gcmap_front, gcmap_fifo, gcmap_back (and gcmap_ram below it)
// read path: an accepted read passes the queue, the registered ram read and the response register
// throughput: set_kind and set_amount each take one ram read and one write, a read takes one ram
//   read and waits for a free response register; stamp_area walks the clipped cells, one cell per
//   cycle on the single ram port pair; out-of-grid writes are dropped at the front, out-of-grid reads skip the ram
// reset: synchronous, active high; afterwards a clearing pass over all MAX_COLUMNS * MAX_ROWS cells
//   zeroes the cell ram, req_tready stays low during it, config writes are taken throughout
module grid_cover_map_area_stamp #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pos_x[6:0], pos_y[13:7], radius[20:14], amount[25:21],
                                    // kind[27:26], zero fill[31:28]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // amount_out[4:0], kind_out[6:5], zero fill[7]
   output logic [0:0]  rsp_tuser,   // bad_position[0]
   // register writes
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,    // 0 grid_width, 1 grid_height
   input  logic [7:0]  csr_wdata
);

   // front to queue
   logic                push;
   gcmap_pkg::desc_type push_desc;
   // queue to back
   gcmap_pkg::desc_type head;
   logic                pop, fifo_full, fifo_empty;
   // back end busy zeroing the store
   logic                clearing;

   // front: register file, clipping of the square, dropping of out-of-grid writes
   gcmap_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .clearing   (clearing),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_desc  (push_desc)
   );

   // two descriptors of slack so the front keeps taking requests during a long stamp
   gcmap_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   // back: cell walk with read-modify-write, clearing pass, response register
   gcmap_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (fifo_empty),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: hdl/gcmap_checker.sv
// gcmap_port_checks: port-level checks of the cover map stamp block, bound to the top level
// depends on grid_cover_map_area_stamp
module gcmap_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser
);

   // no response right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // clearing pass blocks requests right after reset
   a_no_req_while_clearing: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // out-of-grid read reports zero amount and kind
   a_bad_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("flagged read carries data");

endmodule

bind grid_cover_map_area_stamp gcmap_port_checks u_port_checks (.*);

FILE: tb/gcmap_checker.sv
// gcmap_checker: passive watcher for the cover map stamp block, keeps its own cell grid
// and grid size copy, predicts every read response and compares them in order
// depends on gcmap_pkg
`timescale 1ns / 100ps

module gcmap_checker #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // pos_x[6:0], pos_y[13:7], radius[20:14], amount[25:21],
                                    // kind[27:26], zero fill[31:28]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // amount_out[4:0], kind_out[6:5], zero fill[7]
   input  logic [0:0]  rsp_tuser,   // bad_position[0]
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending_reads,
   output int          reads_checked,
   output int          flagged_reads
);

   typedef struct {
      logic [gcmap_pkg::AMOUNT_W-1:0] amount;
      logic [gcmap_pkg::KIND_W-1:0]   kind;
      logic                           off_grid;
   } cell_report_type;

   cell_report_type                  read_reports[$];
   logic [gcmap_pkg::CELL_W-1:0]     cover_cells [MAX_COLUMNS*MAX_ROWS];
   logic [gcmap_pkg::CSR_DATA_W-1:0] grid_cols_reg;
   logic [gcmap_pkg::CSR_DATA_W-1:0] grid_rows_reg;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   function automatic int cols_used();
      return (int'(grid_cols_reg) > MAX_COLUMNS) ? MAX_COLUMNS : int'(grid_cols_reg);
   endfunction

   function automatic int rows_used();
      return (int'(grid_rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(grid_rows_reg);
   endfunction

   function automatic bit on_grid(input int x, input int y);
      return (x < cols_used()) && (y < rows_used());
   endfunction

   function automatic void mark_kind(input int idx, input logic [gcmap_pkg::KIND_W-1:0] kind);
      case (kind)
         gcmap_pkg::KIND_NONE:
            cover_cells[idx][gcmap_pkg::FLAG_SOLID_BIT:gcmap_pkg::FLAG_VEG_BIT] = '0;
         gcmap_pkg::KIND_VEGETATION: cover_cells[idx][gcmap_pkg::FLAG_VEG_BIT] = 1'b1;
         gcmap_pkg::KIND_TREE:       cover_cells[idx][gcmap_pkg::FLAG_TREE_BIT] = 1'b1;
         default:                    cover_cells[idx][gcmap_pkg::FLAG_SOLID_BIT] = 1'b1;
      endcase
   endfunction

   function automatic logic [gcmap_pkg::KIND_W-1:0] top_kind(
      input logic [gcmap_pkg::CELL_W-1:0] cell_bits);
      if (cell_bits[gcmap_pkg::FLAG_VEG_BIT])
         return gcmap_pkg::KIND_VEGETATION;
      if (cell_bits[gcmap_pkg::FLAG_TREE_BIT])
         return gcmap_pkg::KIND_TREE;
      if (cell_bits[gcmap_pkg::FLAG_SOLID_BIT])
         return gcmap_pkg::KIND_SOLID;
      return gcmap_pkg::KIND_NONE;
   endfunction

   // drop a centre off the grid, else clip the square to the grid in use, then apply kind and raise amount cell by cell
   function automatic void stamp_square(input int x, input int y, input int r,
                                        input logic [gcmap_pkg::AMOUNT_W-1:0] amt,
                                        input logic [gcmap_pkg::KIND_W-1:0] kind);
      int x_lo, x_hi, y_lo, y_hi, idx;
      if (!on_grid(x, y))
         return;
      x_lo = (x > r) ? x - r : 0;
      y_lo = (y > r) ? y - r : 0;
      x_hi = (x + r > cols_used() - 1) ? cols_used() - 1 : x + r;
      y_hi = (y + r > rows_used() - 1) ? rows_used() - 1 : y + r;
      for (int cy = y_lo; cy <= y_hi; cy++) begin
         for (int cx = x_lo; cx <= x_hi; cx++) begin
            idx = cy * MAX_COLUMNS + cx;
            mark_kind(idx, kind);
            if (cover_cells[idx][gcmap_pkg::AMOUNT_W-1:0] < amt)
               cover_cells[idx][gcmap_pkg::AMOUNT_W-1:0] = amt;
         end
      end
   endfunction

   task automatic take_request(input logic [31:0] data, input logic [1:0] user);
      int x, y, r, idx;
      logic [gcmap_pkg::AMOUNT_W-1:0] amt;
      logic [gcmap_pkg::KIND_W-1:0] kind;
      cell_report_type rep;
      x    = int'(data[6:0]);
      y    = int'(data[13:7]);
      r    = int'(data[20:14]);
      amt  = data[25:21];
      kind = data[27:26];
      idx  = y * MAX_COLUMNS + x;
      case (gcmap_pkg::cmd_type'(user))
         gcmap_pkg::CMD_SET_KIND: begin
            if (on_grid(x, y))
               mark_kind(idx, kind);
         end
         gcmap_pkg::CMD_SET_AMOUNT: begin
            if (on_grid(x, y))
               cover_cells[idx][gcmap_pkg::AMOUNT_W-1:0] = amt;
         end
         gcmap_pkg::CMD_STAMP_AREA: begin
            stamp_square(x, y, r, amt, kind);
         end
         default: begin
            if (on_grid(x, y)) begin
               rep.amount   = cover_cells[idx][gcmap_pkg::AMOUNT_W-1:0];
               rep.kind     = top_kind(cover_cells[idx]);
               rep.off_grid = 1'b0;
            end else begin
               rep.amount   = '0;
               rep.kind     = gcmap_pkg::KIND_NONE;
               rep.off_grid = 1'b1;
            end
            read_reports.push_back(rep);
         end
      endcase
   endtask

   task automatic take_response();
      cell_report_type want;
      if (read_reports.size() == 0) begin
         report_mismatch("response with no read pending", int'(rsp_tdata), -1);
         return;
      end
      want = read_reports.pop_front();
      if (rsp_tdata[4:0] !== want.amount)
         report_mismatch("amount_out", int'(rsp_tdata[4:0]), int'(want.amount));
      if (rsp_tdata[6:5] !== want.kind)
         report_mismatch("kind_out", int'(rsp_tdata[6:5]), int'(want.kind));
      if (rsp_tuser[0] !== want.off_grid)
         report_mismatch("bad_position", int'(rsp_tuser[0]), int'(want.off_grid));
      reads_checked++;
      if (want.off_grid)
         flagged_reads++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_COLUMNS * MAX_ROWS; i++)
            cover_cells[i] = '0;
         grid_cols_reg = gcmap_pkg::GRID_SIZE_RESET;
         grid_rows_reg = gcmap_pkg::GRID_SIZE_RESET;
         read_reports.delete();
         fail_count    = 0;
         reads_checked = 0;
         flagged_reads = 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == gcmap_pkg::CSR_GRID_WIDTH)
               grid_cols_reg = csr_wdata;
            else
               grid_rows_reg = csr_wdata;
         end
         if (req_tvalid && req_tready)
            take_request(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready)
            take_response();
      end
      pending_reads = read_reports.size();
   end

endmodule

FILE: tb/tb.sv
// tb: stimulus and verdict for the cover map stamp block; drives requests, grid size
// writes and response backpressure, the checker beside the block does all comparing
// depends on gcmap_pkg, gcmap_checker and the block's rtl
`timescale 1ns / 100ps

module tb;

   localparam int COLUMNS = 128;
   localparam int ROWS    = 128;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_addr   = '0;
   logic [7:0]  csr_wdata  = '0;

   int fail_count;
   int pending_reads;
   int reads_checked;
   int flagged_reads;

   // sender pacing: bursts with gaps alternate with bursts without any
   int gap_run_left = 0;
   bit gaps_on      = 1'b1;
   bit tight_burst  = 1'b0;

   // bumped by the stimulus to ask the receiver for one long hold-off
   int squeeze_reqs = 0;

   int sent_count   = 0;
   int stamp_count  = 0;
   int big_stamps   = 0;
   int grid_sizes   = 0;

   always #2 clock = ~clock;

   grid_cover_map_area_stamp #(
      .MAX_COLUMNS (COLUMNS),
      .MAX_ROWS    (ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   gcmap_checker #(
      .MAX_COLUMNS (COLUMNS),
      .MAX_ROWS    (ROWS)
   ) cover_watch (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_reads (pending_reads),
      .reads_checked (reads_checked),
      .flagged_reads (flagged_reads)
   );

   // gap before the next request: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      if (tight_burst)
         return 0;
      if (gap_run_left == 0) begin
         gap_run_left = $urandom_range(20, 60);
         gaps_on      = ($urandom_range(0, 3) != 0);
      end
      gap_run_left--;
      if (!gaps_on)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance;
   // valid stays high into the next request when there is no gap
   task automatic send_request(input gcmap_pkg::cmd_type cmd, input int x, input int y,
                               input int r, input int amt, input int kind);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, kind[1:0], amt[4:0], r[6:0], y[6:0], x[6:0]};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      sent_count++;
      if (cmd == gcmap_pkg::CMD_STAMP_AREA)
         stamp_count++;
   endtask

   // both size registers, one write each on consecutive cycles; only while idle
   task automatic write_grid(input int cols, input int rows);
      csr_we    <= 1'b1;
      csr_addr  <= gcmap_pkg::CSR_GRID_WIDTH;
      csr_wdata <= cols[7:0];
      @(negedge clock);
      csr_addr  <= gcmap_pkg::CSR_GRID_HEIGHT;
      csr_wdata <= rows[7:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      grid_sizes++;
   endtask

   // a trailing read goes through the block in order, so once its response is
   // back every stamp ahead of it has finished too; a few spare cycles on top
   task automatic settle();
      send_request(gcmap_pkg::CMD_READ, 0, 0, 0, 0, gcmap_pkg::KIND_NONE);
      req_tvalid <= 1'b0;
      while (pending_reads != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // coordinates cluster near the origin and near the far edge of the grid in use,
   // so reads land on written cells and clipping gets exercised
   function automatic int pick_coord(input int used);
      int roll, v;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return $urandom_range(0, 7);
      if (roll < 70) begin
         v = used + int'($urandom_range(0, 4)) - 3;
         if (v < 0)
            v = 0;
         if (v > 127)
            v = 127;
         return v;
      end
      return $urandom_range(0, 127);
   endfunction

   task automatic random_request(input int used_cols, input int used_rows);
      int roll, wide, x, y, r, amt, kind;
      gcmap_pkg::cmd_type cmd;
      roll = $urandom_range(0, 99);
      x    = pick_coord(used_cols);
      y    = pick_coord(used_rows);
      r    = $urandom_range(0, 3);
      amt  = $urandom_range(0, 31);
      kind = $urandom_range(0, 3);
      if (roll < 35)
         cmd = gcmap_pkg::CMD_READ;
      else if (roll < 60)
         cmd = gcmap_pkg::CMD_STAMP_AREA;
      else if (roll < 80)
         cmd = gcmap_pkg::CMD_SET_KIND;
      else
         cmd = gcmap_pkg::CMD_SET_AMOUNT;
      if (cmd == gcmap_pkg::CMD_STAMP_AREA) begin
         wide = $urandom_range(0, 99);
         // full radius range is cheap on small grids, rationed on large ones
         if (used_cols * used_rows <= 1024 && wide < 30) begin
            r = $urandom_range(0, 127);
         end else if (wide < 2 && big_stamps < 8) begin
            r = $urandom_range(0, 127);
            big_stamps++;
         end else if (wide < 15) begin
            r = $urandom_range(4, 12);
         end
      end
      send_request(cmd, x, y, r, amt, kind);
   endtask

   task automatic random_phase(input int cols, input int rows, input int count);
      int used_cols, used_rows;
      used_cols = (cols > COLUMNS) ? COLUMNS : cols;
      used_rows = (rows > ROWS) ? ROWS : rows;
      repeat (count)
         random_request(used_cols, used_rows);
   endtask

   // receiver: random ready runs and stalls, plus one long hold-off on demand
   initial begin : receiver
      int hold_left, run_left, stall_left, roll, squeeze_done;
      hold_left    = 0;
      run_left     = 0;
      stall_left   = 0;
      squeeze_done = 0;
      forever begin
         @(negedge clock);
         if (squeeze_done != squeeze_reqs) begin
            squeeze_done = squeeze_reqs;
            hold_left    = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            run_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 120);
            roll     = $urandom_range(0, 99);
            if (roll < 30)
               stall_left = 0;
            else if (roll < 90)
               stall_left = $urandom_range(1, 3);
            else
               stall_left = $urandom_range(8, 40);
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit: far above the slowest legal run including the clearing pass
   initial begin : watchdog
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset size 128 x 128, ram just cleared; request ready holds off until the
      // clearing pass is over
      send_request(gcmap_pkg::CMD_READ,       0,   0,   0,  0, gcmap_pkg::KIND_NONE);
      // flags accumulate, priority picks vegetation
      send_request(gcmap_pkg::CMD_SET_KIND,   0,   0,   0,  0, gcmap_pkg::KIND_VEGETATION);
      send_request(gcmap_pkg::CMD_SET_KIND,   0,   0,   0,  0, gcmap_pkg::KIND_TREE);
      send_request(gcmap_pkg::CMD_SET_KIND,   0,   0,   0,  0, gcmap_pkg::KIND_SOLID);
      send_request(gcmap_pkg::CMD_READ,       0,   0,   0,  0, gcmap_pkg::KIND_NONE);
      // kind none wipes all three flags
      send_request(gcmap_pkg::CMD_SET_KIND,   0,   0,   0,  0, gcmap_pkg::KIND_NONE);
      send_request(gcmap_pkg::CMD_SET_AMOUNT, 127, 127, 0,  31, gcmap_pkg::KIND_NONE);
      send_request(gcmap_pkg::CMD_SET_KIND,   127, 127, 0,  0, gcmap_pkg::KIND_SOLID);
      send_request(gcmap_pkg::CMD_READ,       127, 127, 0,  0, gcmap_pkg::KIND_NONE);
      send_request(gcmap_pkg::CMD_READ,       0,   0,   0,  0, gcmap_pkg::KIND_NONE);
      send_request(gcmap_pkg::CMD_SET_AMOUNT, 127, 127, 0,  0, gcmap_pkg::KIND_NONE);
      // zero radius touches the centre only
      send_request(gcmap_pkg::CMD_STAMP_AREA, 1,   1,   0,  7, gcmap_pkg::KIND_TREE);
      send_request(gcmap_pkg::CMD_READ,       1,   1,   0,  0, gcmap_pkg::KIND_NONE);
      send_request(gcmap_pkg::CMD_READ,       2,   2,   0,  0, gcmap_pkg::KIND_NONE);
      // zero stamp amount: kind only, clipped at the right edge
      send_request(gcmap_pkg::CMD_STAMP_AREA, 126, 0,   3,  0, gcmap_pkg::KIND_VEGETATION);
      send_request(gcmap_pkg::CMD_READ,       127, 0,   0,  0, gcmap_pkg::KIND_NONE);
      // largest radius covers the whole grid
      send_request(gcmap_pkg::CMD_STAMP_AREA, 64,  64,  127, 31, gcmap_pkg::KIND_SOLID);
      send_request(gcmap_pkg::CMD_READ,       0,   127, 0,  0, gcmap_pkg::KIND_NONE);
      // a lower stamp amount never lowers a cell
      send_request(gcmap_pkg::CMD_STAMP_AREA, 5,   5,   2,  3, gcmap_pkg::KIND_TREE);
      send_request(gcmap_pkg::CMD_READ,       5,   5,   0,  0, gcmap_pkg::KIND_NONE);
      settle();

      // small grid: writes and a stamp centre outside it are dropped, reads flagged
      write_grid(10, 6);
      send_request(gcmap_pkg::CMD_SET_AMOUNT, 12,  3,   0,  9, gcmap_pkg::KIND_NONE);
      send_request(gcmap_pkg::CMD_STAMP_AREA, 3,   6,   5,  17, gcmap_pkg::KIND_VEGETATION);
      send_request(gcmap_pkg::CMD_STAMP_AREA, 9,   5,   127, 20, gcmap_pkg::KIND_NONE);
      send_request(gcmap_pkg::CMD_READ,       10,  0,   0,  0, gcmap_pkg::KIND_NONE);
      send_request(gcmap_pkg::CMD_READ,       0,   6,   0,  0, gcmap_pkg::KIND_NONE);
      send_request(gcmap_pkg::CMD_READ,       9,   5,   0,  0, gcmap_pkg::KIND_NONE);
      random_phase(10, 6, 120);
      settle();

      // empty grid: nothing is in use
      write_grid(0, 5);
      send_request(gcmap_pkg::CMD_SET_KIND,   0,   0,   0,  0, gcmap_pkg::KIND_VEGETATION);
      send_request(gcmap_pkg::CMD_READ,       0,   0,   0,  0, gcmap_pkg::KIND_NONE);
      random_phase(0, 5, 40);
      settle();

      // oversized grid acts as the full one; the dropped write above must not show
      write_grid(255, 255);
      send_request(gcmap_pkg::CMD_READ,       12,  3,   0,  0, gcmap_pkg::KIND_NONE);
      random_phase(255, 255, 150);
      settle();

      // full grid; a burst of reads while the receiver holds off fills the block
      // until it stops taking requests
      write_grid(128, 128);
      squeeze_reqs++;
      tight_burst = 1'b1;
      repeat (48)
         send_request(gcmap_pkg::CMD_READ, pick_coord(COLUMNS), pick_coord(ROWS), 0, 0,
                      gcmap_pkg::KIND_NONE);
      tight_burst = 1'b0;
      random_phase(128, 128, 250);
      settle();

      write_grid(1, 1);
      random_phase(1, 1, 60);
      settle();

      write_grid(128, 1);
      random_phase(128, 1, 100);
      settle();

      write_grid(37, 90);
      random_phase(37, 90, 150);
      settle();

      write_grid(1, 128);
      random_phase(1, 128, 80);
      settle();

      write_grid(5, 0);
      random_phase(5, 0, 20);
      settle();

      write_grid(128, 128);
      random_phase(128, 128, 80);
      settle();

      // settle left nothing pending; give a late stray response time to show
      repeat (32) @(negedge clock);

      $display("covered %0d requests over %0d grid sizes, %0d of them area stamps (%0d wide)",
               sent_count, grid_sizes, stamp_count, big_stamps);
      $display("checked %0d read responses, %0d flagged out of grid, one long receiver stall",
               reads_checked, flagged_reads);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: grid_cover_map_area_stamp.f
hdl/gcmap_pkg.sv
hdl/gcmap_ram.sv
hdl/gcmap_fifo.sv
hdl/gcmap_front.sv
hdl/gcmap_back.sv
hdl/grid_cover_map_area_stamp.sv
hdl/gcmap_checker.sv
tb/gcmap_checker.sv
tb/tb.sv
